/* sv/lups_pkg.sv */
// shared constants, handshake structs and fixed-point helpers for the lu solver
`timescale 1ns / 1ps

package lups_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int IDX_W     = 4;
    localparam int SIZE_W    = 5;
    localparam int FX_W      = 48;
    localparam int FRAC_BITS = 32;
    localparam int Q_SHIFT   = FRAC_BITS - 16;

    localparam logic [1:0] ACT_MAT   = 2'd0;
    localparam logic [1:0] ACT_RHS   = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;

    localparam logic signed [FX_W-1:0] FX_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [FX_W-1:0] FX_MIN = 48'sh8000_0000_0000;
    localparam logic [FX_W-1:0]        MAG_ONE = 48'h0001_0000_0000;

    typedef struct packed {
        logic                   start;
        logic signed [FX_W-1:0] a;
        logic signed [FX_W-1:0] b;
        logic                   force_pos;
    } mul_req_t;

    typedef struct packed {
        logic            start;
        logic [FX_W-1:0] ma;
        logic [FX_W-1:0] mb;
        logic            neg;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [FX_W-1:0] res;
    } unit_rsp_t;

    function automatic logic [FX_W-1:0] fx_mag(input logic signed [FX_W-1:0] a);
        logic [FX_W-1:0] u;
        u = a;
        return u[FX_W-1] ? (~u + 48'd1) : u;
    endfunction

    // saturate a magnitude with sign to the 48-bit range
    function automatic logic signed [FX_W-1:0] fx_pack(input logic [63:0] m,
                                                       input logic neg,
                                                       input logic ovf);
        logic [FX_W-1:0] low;
        low = m[FX_W-1:0];
        if (neg) begin
            if (ovf || m > 64'h0000_8000_0000_0000) begin
                return FX_MIN;
            end
            return signed'(48'd0 - low);
        end
        if (ovf || m > 64'h0000_7FFF_FFFF_FFFF) begin
            return FX_MAX;
        end
        return signed'(low);
    endfunction

endpackage

/* sv/lups_mul.sv */
// fixed-point multiplier built from four 24x24 partial products over cycles
`timescale 1ns / 1ps

module lups_mul
    import lups_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mul_req_t  req,
    output unit_rsp_t rsp
);

    logic            busy_reg, busy_next;
    logic [2:0]      step_reg, step_next;
    logic [FX_W-1:0] ma_reg, ma_next;
    logic [FX_W-1:0] mb_reg, mb_next;
    logic            neg_reg, neg_next;
    logic [47:0]     pp_reg, pp_next;
    logic [1:0]      sh_reg, sh_next;
    logic [95:0]     acc_reg, acc_next;
    logic            done_reg, done_next;
    logic signed [FX_W-1:0] p_reg, p_next;
    logic [95:0]     pp_shift;

    always_comb
    begin
        unique case (sh_reg)
            2'd0:    pp_shift = {48'd0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 48'd0};
            default: pp_shift = {24'd0, pp_reg, 24'd0};
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        p_next    = p_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            ma_next   = fx_mag(req.a);
            mb_next   = fx_mag(req.b);
            neg_next  = !req.force_pos && (req.a[FX_W-1] != req.b[FX_W-1]);
            acc_next  = 96'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg < 3'd4) begin
                sh_next = step_reg[1:0];
                unique case (step_reg[1:0])
                    2'd0: pp_next = ma_reg[23:0] * mb_reg[23:0];
                    2'd1: pp_next = ma_reg[23:0] * mb_reg[47:24];
                    2'd2: pp_next = ma_reg[47:24] * mb_reg[23:0];
                    2'd3: pp_next = ma_reg[47:24] * mb_reg[47:24];
                endcase
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                acc_next = acc_reg + pp_shift;
            end
            if (step_reg == 3'd5) begin
                p_next    = fx_pack(acc_reg[95:32], neg_reg, 1'b0);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = p_reg;

endmodule

/* sv/lups_div.sv */
// radix-2 restoring divider for fixed-point quotients, one bit a cycle
`timescale 1ns / 1ps

module lups_div
    import lups_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output unit_rsp_t rsp
);

    logic            busy_reg, busy_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [79:0]     dvd_reg, dvd_next;
    logic [FX_W-1:0] r_reg, r_next;
    logic [FX_W-1:0] mb_reg, mb_next;
    logic [FX_W:0]   q_reg, q_next;
    logic            ovf_reg, ovf_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next;
    logic signed [FX_W-1:0] res_reg, res_next;
    logic [FX_W:0]   rs;
    logic            ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        r_next    = r_reg;
        mb_next   = mb_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        rs        = {r_reg, dvd_reg[79]};
        ge        = rs >= {1'b0, mb_reg};
        if (req.start) begin
            neg_next = req.neg;
            mb_next  = req.mb;
            if (req.mb == '0) begin
                // divide by zero: zero over zero is zero, else full scale
                done_next = 1'b1;
                res_next  = (req.ma == '0) ? '0 : (req.neg ? FX_MIN : FX_MAX);
            end else begin
                busy_next = 1'b1;
                cnt_next  = 7'd0;
                dvd_next  = {req.ma, 32'd0};
                r_next    = '0;
                q_next    = '0;
                ovf_next  = 1'b0;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg < 7'd80) begin
                dvd_next = {dvd_reg[78:0], 1'b0};
                r_next   = ge ? FX_W'(rs - {1'b0, mb_reg}) : rs[FX_W-1:0];
                q_next   = {q_reg[FX_W-1:0], ge};
                ovf_next = ovf_reg || q_next[FX_W]
                           || (q_next[FX_W-1] && (q_next[FX_W-2:0] != '0));
            end else begin
                res_next  = fx_pack({15'd0, q_reg}, neg_reg, ovf_reg);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        r_reg   <= r_next;
        mb_reg  <= mb_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

/* sv/lu_pivot_linear_solver_top.sv */
// dense linear solver: crout lu with scaled partial pivoting and substitution
`timescale 1ns / 1ps

// Loads (action 0 matrix entry, action 1 rhs entry) leave busy low. A solve of order
// N runs from sequencer steps around one 256x48 matrix RAM and one 16x48 rhs RAM,
// both with registered reads. Each multiply-subtract step takes two RAM reads and
// a pass through the partial-product multiplier, and there are about N^3/3 of them
// plus N^2 for the substitutions; each of the roughly 3N divisions runs in the
// bit-serial divider. Results then appear one at a time, each on result_strobe for
// a single cycle; the receiver cannot stall, so it must take every transfer as
// shown. A zero row ends the solve with one singular result.

module lu_pivot_linear_solver_top
    import lups_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              action,
    input  logic [IDX_W-1:0]        row,
    input  logic [IDX_W-1:0]        col,
    input  logic signed [31:0]      value,
    output logic                    result_strobe,
    output logic [IDX_W-1:0]        row_index,
    output logic signed [31:0]      solution,
    output logic                    last,
    output logic                    singular,
    output logic                    swap_parity,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SIZE_W-1:0]       cfg_data
);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_SC_ROW  = 6'd1;
    localparam logic [5:0] ST_SC_RD   = 6'd2;
    localparam logic [5:0] ST_SC_CMP  = 6'd3;
    localparam logic [5:0] ST_SC_CHK  = 6'd4;
    localparam logic [5:0] ST_SC_DIVW = 6'd5;
    localparam logic [5:0] ST_LU_COL  = 6'd6;
    localparam logic [5:0] ST_LU_ROW  = 6'd7;
    localparam logic [5:0] ST_LU_SUM0 = 6'd8;
    localparam logic [5:0] ST_LU_KCHK = 6'd9;
    localparam logic [5:0] ST_LU_K1   = 6'd10;
    localparam logic [5:0] ST_LU_K2   = 6'd11;
    localparam logic [5:0] ST_LU_KW   = 6'd12;
    localparam logic [5:0] ST_LU_WR   = 6'd13;
    localparam logic [5:0] ST_LU_PW   = 6'd14;
    localparam logic [5:0] ST_SW_CHK  = 6'd15;
    localparam logic [5:0] ST_SW_R1   = 6'd16;
    localparam logic [5:0] ST_SW_R2   = 6'd17;
    localparam logic [5:0] ST_SW_W1   = 6'd18;
    localparam logic [5:0] ST_SW_W2   = 6'd19;
    localparam logic [5:0] ST_DG_RD   = 6'd20;
    localparam logic [5:0] ST_DG_CHK  = 6'd21;
    localparam logic [5:0] ST_DG_W    = 6'd22;
    localparam logic [5:0] ST_LM_RD   = 6'd23;
    localparam logic [5:0] ST_LM_M    = 6'd24;
    localparam logic [5:0] ST_LM_W    = 6'd25;
    localparam logic [5:0] ST_COL_NX  = 6'd26;
    localparam logic [5:0] ST_FW_ROW  = 6'd27;
    localparam logic [5:0] ST_FW_R1   = 6'd28;
    localparam logic [5:0] ST_FW_R2   = 6'd29;
    localparam logic [5:0] ST_FW_JCHK = 6'd30;
    localparam logic [5:0] ST_FW_J1   = 6'd31;
    localparam logic [5:0] ST_FW_JW   = 6'd32;
    localparam logic [5:0] ST_FW_WR   = 6'd33;
    localparam logic [5:0] ST_BK_ROW  = 6'd34;
    localparam logic [5:0] ST_BK_R1   = 6'd35;
    localparam logic [5:0] ST_BK_JCHK = 6'd36;
    localparam logic [5:0] ST_BK_J1   = 6'd37;
    localparam logic [5:0] ST_BK_JW   = 6'd38;
    localparam logic [5:0] ST_BK_D    = 6'd39;
    localparam logic [5:0] ST_BK_DW   = 6'd40;
    localparam logic [5:0] ST_OUT_RD  = 6'd41;
    localparam logic [5:0] ST_OUT_EM  = 6'd42;

    // memories and small register files
    logic signed [FX_W-1:0] mat_mem [MAX_SIZE*MAX_SIZE];
    logic signed [FX_W-1:0] rhs_mem [MAX_SIZE];
    logic signed [FX_W-1:0] rs_reg  [MAX_SIZE];
    logic [IDX_W-1:0]       piv_reg [MAX_SIZE];

    logic [2*IDX_W-1:0]     mat_raddr, mat_waddr;
    logic                   mat_we;
    logic signed [FX_W-1:0] mat_wdata, mat_rdata;
    logic [IDX_W-1:0]       rhs_raddr, rhs_waddr;
    logic                   rhs_we;
    logic signed [FX_W-1:0] rhs_wdata, rhs_rdata;
    logic                   rs_we;
    logic [IDX_W-1:0]       rs_waddr;
    logic signed [FX_W-1:0] rs_wdata;
    logic                   piv_we;

    logic [5:0]             state_reg, state_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [SIZE_W-1:0]      n_reg, n_next;
    logic [SIZE_W-1:0]      i_reg, i_next;
    logic [SIZE_W-1:0]      j_reg, j_next;
    logic [SIZE_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]       imax_reg, imax_next;
    logic                   parity_reg, parity_next;
    logic signed [FX_W-1:0] big_reg, big_next;
    logic signed [FX_W-1:0] sum_reg, sum_next;
    logic signed [FX_W-1:0] opa_reg, opa_next;
    logic signed [FX_W-1:0] t1_reg, t1_next;
    logic signed [FX_W-1:0] dum_reg, dum_next;
    logic [FX_W-1:0]        mx_reg, mx_next;

    logic                   strobe_reg, strobe_next;
    logic [IDX_W-1:0]       ridx_reg, ridx_next;
    logic signed [31:0]     sol_reg, sol_next;
    logic                   last_reg, last_next;
    logic                   sing_reg, sing_next;
    logic                   spar_reg, spar_next;

    mul_req_t               mul_req;
    div_req_t               div_req;
    unit_rsp_t              mul_rsp, div_rsp;

    logic [SIZE_W-1:0]      kmax;
    logic [FX_W-1:0]        rd_mag;
    logic signed [FX_W-1:0] diag;
    logic [IDX_W-1:0]       ii, jj, kk;

    function automatic logic signed [FX_W-1:0] fx_sub(input logic signed [FX_W-1:0] a,
                                                      input logic signed [FX_W-1:0] b);
        logic [FX_W:0] d;
        d = {a[FX_W-1], a} - {b[FX_W-1], b};
        if (d[FX_W] != d[FX_W-1]) begin
            return d[FX_W] ? FX_MIN : FX_MAX;
        end
        return signed'(d[FX_W-1:0]);
    endfunction

    lups_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    lups_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ii     = i_reg[IDX_W-1:0];
    assign jj     = j_reg[IDX_W-1:0];
    assign kk     = k_reg[IDX_W-1:0];
    assign kmax   = (i_reg < j_reg) ? i_reg : j_reg;
    assign rd_mag = fx_mag(mat_rdata);
    assign diag   = (mat_rdata == '0) ? 48'sd1 : mat_rdata;

    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        imax_next   = imax_reg;
        parity_next = parity_reg;
        big_next    = big_reg;
        sum_next    = sum_reg;
        opa_next    = opa_reg;
        t1_next     = t1_reg;
        dum_next    = dum_reg;
        mx_next     = mx_reg;
        strobe_next = 1'b0;
        ridx_next   = ridx_reg;
        sol_next    = sol_reg;
        last_next   = last_reg;
        sing_next   = sing_reg;
        spar_next   = spar_reg;

        mat_raddr   = {ii, jj};
        mat_waddr   = {ii, jj};
        mat_we      = 1'b0;
        mat_wdata   = sum_reg;
        rhs_raddr   = ii;
        rhs_waddr   = ii;
        rhs_we      = 1'b0;
        rhs_wdata   = sum_reg;
        rs_we       = 1'b0;
        rs_waddr    = ii;
        rs_wdata    = div_rsp.res;
        piv_we      = 1'b0;

        mul_req.start     = 1'b0;
        mul_req.a         = mat_rdata;
        mul_req.b         = rhs_rdata;
        mul_req.force_pos = 1'b0;
        div_req.start     = 1'b0;
        div_req.ma        = MAG_ONE;
        div_req.mb        = mx_reg;
        div_req.neg       = 1'b0;

        if (cfg_valid && cfg_ready) begin
            size_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    unique case (action)
                        ACT_MAT:
                        begin
                            mat_we    = 1'b1;
                            mat_waddr = {row, col};
                            mat_wdata = {value, {Q_SHIFT{1'b0}}};
                        end
                        ACT_RHS:
                        begin
                            rhs_we    = 1'b1;
                            rhs_waddr = row;
                            rhs_wdata = {value, {Q_SHIFT{1'b0}}};
                        end
                        ACT_SOLVE:
                        begin
                            if (size_reg == '0) begin
                                n_next = SIZE_W'(1);
                            end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
                                n_next = SIZE_W'(MAX_SIZE);
                            end else begin
                                n_next = size_reg;
                            end
                            parity_next = 1'b0;
                            i_next      = '0;
                            state_next  = ST_SC_ROW;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SC_ROW:
            begin
                j_next     = '0;
                mx_next    = '0;
                state_next = ST_SC_RD;
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_CMP;
            end
            ST_SC_CMP:
            begin
                if (rd_mag > mx_reg) begin
                    mx_next = rd_mag;
                end
                j_next     = j_reg + 5'd1;
                state_next = (j_reg + 5'd1 == n_reg) ? ST_SC_CHK : ST_SC_RD;
            end
            ST_SC_CHK:
            begin
                if (mx_reg == '0) begin
                    strobe_next = 1'b1;
                    ridx_next   = ii;
                    sol_next    = '0;
                    last_next   = 1'b1;
                    sing_next   = 1'b1;
                    spar_next   = 1'b0;
                    state_next  = ST_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_SC_DIVW;
                end
            end
            ST_SC_DIVW:
            begin
                if (div_rsp.done) begin
                    rs_we = 1'b1;
                    if (i_reg + 5'd1 == n_reg) begin
                        j_next     = '0;
                        state_next = ST_LU_COL;
                    end else begin
                        i_next     = i_reg + 5'd1;
                        state_next = ST_SC_ROW;
                    end
                end
            end
            ST_LU_COL:
            begin
                i_next     = '0;
                big_next   = '0;
                imax_next  = jj;
                state_next = ST_LU_ROW;
            end
            ST_LU_ROW:
            begin
                k_next     = '0;
                state_next = ST_LU_SUM0;
            end
            ST_LU_SUM0:
            begin
                sum_next   = mat_rdata;
                state_next = ST_LU_KCHK;
            end
            ST_LU_KCHK:
            begin
                if (k_reg < kmax) begin
                    mat_raddr  = {ii, kk};
                    state_next = ST_LU_K1;
                end else begin
                    state_next = ST_LU_WR;
                end
            end
            ST_LU_K1:
            begin
                opa_next   = mat_rdata;
                mat_raddr  = {kk, jj};
                state_next = ST_LU_K2;
            end
            ST_LU_K2:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = opa_reg;
                mul_req.b     = mat_rdata;
                state_next    = ST_LU_KW;
            end
            ST_LU_KW:
            begin
                if (mul_rsp.done) begin
                    sum_next   = fx_sub(sum_reg, mul_rsp.res);
                    k_next     = k_reg + 5'd1;
                    state_next = ST_LU_KCHK;
                end
            end
            ST_LU_WR:
            begin
                mat_we = 1'b1;
                if (i_reg < j_reg) begin
                    i_next     = i_reg + 5'd1;
                    state_next = ST_LU_ROW;
                end else begin
                    // scaled magnitude for the pivot search
                    mul_req.start     = 1'b1;
                    mul_req.a         = rs_reg[ii];
                    mul_req.b         = sum_reg;
                    mul_req.force_pos = 1'b1;
                    state_next        = ST_LU_PW;
                end
            end
            ST_LU_PW:
            begin
                if (mul_rsp.done) begin
                    if (mul_rsp.res >= big_reg) begin
                        big_next  = mul_rsp.res;
                        imax_next = ii;
                    end
                    if (i_reg + 5'd1 == n_reg) begin
                        state_next = ST_SW_CHK;
                    end else begin
                        i_next     = i_reg + 5'd1;
                        state_next = ST_LU_ROW;
                    end
                end
            end
            ST_SW_CHK:
            begin
                piv_we = 1'b1;
                if (imax_reg != jj) begin
                    parity_next = !parity_reg;
                    rs_we       = 1'b1;
                    rs_waddr    = imax_reg;
                    rs_wdata    = rs_reg[jj];
                    k_next      = '0;
                    state_next  = ST_SW_R1;
                end else begin
                    state_next = ST_DG_RD;
                end
            end
            ST_SW_R1:
            begin
                mat_raddr  = {imax_reg, kk};
                state_next = ST_SW_R2;
            end
            ST_SW_R2:
            begin
                t1_next    = mat_rdata;
                mat_raddr  = {jj, kk};
                state_next = ST_SW_W1;
            end
            ST_SW_W1:
            begin
                mat_we     = 1'b1;
                mat_waddr  = {imax_reg, kk};
                mat_wdata  = mat_rdata;
                state_next = ST_SW_W2;
            end
            ST_SW_W2:
            begin
                mat_we     = 1'b1;
                mat_waddr  = {jj, kk};
                mat_wdata  = t1_reg;
                k_next     = k_reg + 5'd1;
                state_next = (k_reg + 5'd1 == n_reg) ? ST_DG_RD : ST_SW_R1;
            end
            ST_DG_RD:
            begin
                mat_raddr  = {jj, jj};
                state_next = ST_DG_CHK;
            end
            ST_DG_CHK:
            begin
                // zero pivot stands in as one lsb
                if (mat_rdata == '0) begin
                    mat_we    = 1'b1;
                    mat_waddr = {jj, jj};
                    mat_wdata = 48'sd1;
                end
                if (j_reg + 5'd1 == n_reg) begin
                    state_next = ST_COL_NX;
                end else begin
                    div_req.start = 1'b1;
                    div_req.mb    = fx_mag(diag);
                    div_req.neg   = diag[FX_W-1];
                    state_next    = ST_DG_W;
                end
            end
            ST_DG_W:
            begin
                if (div_rsp.done) begin
                    dum_next   = div_rsp.res;
                    i_next     = j_reg + 5'd1;
                    state_next = ST_LM_RD;
                end
            end
            ST_LM_RD:
            begin
                state_next = ST_LM_M;
            end
            ST_LM_M:
            begin
                mul_req.start = 1'b1;
                mul_req.b     = dum_reg;
                state_next    = ST_LM_W;
            end
            ST_LM_W:
            begin
                if (mul_rsp.done) begin
                    mat_we    = 1'b1;
                    mat_wdata = mul_rsp.res;
                    if (i_reg + 5'd1 == n_reg) begin
                        state_next = ST_COL_NX;
                    end else begin
                        i_next     = i_reg + 5'd1;
                        state_next = ST_LM_RD;
                    end
                end
            end
            ST_COL_NX:
            begin
                if (j_reg + 5'd1 == n_reg) begin
                    i_next     = '0;
                    state_next = ST_FW_ROW;
                end else begin
                    j_next     = j_reg + 5'd1;
                    state_next = ST_LU_COL;
                end
            end
            ST_FW_ROW:
            begin
                rhs_raddr  = piv_reg[ii];
                state_next = ST_FW_R1;
            end
            ST_FW_R1:
            begin
                sum_next   = rhs_rdata;
                state_next = ST_FW_R2;
            end
            ST_FW_R2:
            begin
                rhs_we     = 1'b1;
                rhs_waddr  = piv_reg[ii];
                rhs_wdata  = rhs_rdata;
                j_next     = '0;
                state_next = ST_FW_JCHK;
            end
            ST_FW_JCHK:
            begin
                if (j_reg < i_reg) begin
                    rhs_raddr  = jj;
                    state_next = ST_FW_J1;
                end else begin
                    state_next = ST_FW_WR;
                end
            end
            ST_FW_J1:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_FW_JW;
            end
            ST_FW_JW:
            begin
                if (mul_rsp.done) begin
                    sum_next   = fx_sub(sum_reg, mul_rsp.res);
                    j_next     = j_reg + 5'd1;
                    state_next = ST_FW_JCHK;
                end
            end
            ST_FW_WR:
            begin
                rhs_we = 1'b1;
                if (i_reg + 5'd1 == n_reg) begin
                    state_next = ST_BK_ROW;
                end else begin
                    i_next     = i_reg + 5'd1;
                    state_next = ST_FW_ROW;
                end
            end
            ST_BK_ROW:
            begin
                state_next = ST_BK_R1;
            end
            ST_BK_R1:
            begin
                sum_next   = rhs_rdata;
                j_next     = i_reg + 5'd1;
                state_next = ST_BK_JCHK;
            end
            ST_BK_JCHK:
            begin
                if (j_reg < n_reg) begin
                    rhs_raddr  = jj;
                    state_next = ST_BK_J1;
                end else begin
                    mat_raddr  = {ii, ii};
                    state_next = ST_BK_D;
                end
            end
            ST_BK_J1:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_BK_JW;
            end
            ST_BK_JW:
            begin
                if (mul_rsp.done) begin
                    sum_next   = fx_sub(sum_reg, mul_rsp.res);
                    j_next     = j_reg + 5'd1;
                    state_next = ST_BK_JCHK;
                end
            end
            ST_BK_D:
            begin
                div_req.start = 1'b1;
                div_req.ma    = fx_mag(sum_reg);
                div_req.mb    = rd_mag;
                div_req.neg   = sum_reg[FX_W-1] != mat_rdata[FX_W-1];
                state_next    = ST_BK_DW;
            end
            ST_BK_DW:
            begin
                if (div_rsp.done) begin
                    rhs_we    = 1'b1;
                    rhs_wdata = div_rsp.res;
                    if (i_reg == '0) begin
                        state_next = ST_OUT_RD;
                    end else begin
                        i_next     = i_reg - 5'd1;
                        state_next = ST_BK_ROW;
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_EM;
            end
            ST_OUT_EM:
            begin
                strobe_next = 1'b1;
                ridx_next   = ii;
                sol_next    = rhs_rdata[FX_W-1:Q_SHIFT];
                last_next   = (i_reg + 5'd1 == n_reg);
                sing_next   = 1'b0;
                spar_next   = parity_reg;
                if (i_reg + 5'd1 == n_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    i_next     = i_reg + 5'd1;
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // back substitution starts from the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            size_reg   <= SIZE_W'(MAX_SIZE);
            n_reg      <= SIZE_W'(MAX_SIZE);
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            imax_reg   <= '0;
            parity_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            n_reg      <= n_next;
            i_reg      <= (state_reg == ST_FW_WR && state_next == ST_BK_ROW)
                          ? n_reg - 5'd1 : i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            imax_reg   <= imax_next;
            parity_reg <= parity_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg  <= big_next;
        sum_reg  <= sum_next;
        opa_reg  <= opa_next;
        t1_reg   <= t1_next;
        dum_reg  <= dum_next;
        mx_reg   <= mx_next;
        ridx_reg <= ridx_next;
        sol_reg  <= sol_next;
        last_reg <= last_next;
        sing_reg <= sing_next;
        spar_reg <= spar_next;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we) begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        mat_rdata <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we) begin
            rhs_mem[rhs_waddr] <= rhs_wdata;
        end
        rhs_rdata <= rhs_mem[rhs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we) begin
            rs_reg[rs_waddr] <= rs_wdata;
        end
        if (piv_we) begin
            piv_reg[jj] <= imax_reg;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign row_index     = ridx_reg;
    assign solution      = sol_reg;
    assign last          = last_reg;
    assign singular      = sing_reg;
    assign swap_parity   = spar_reg;

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("non-final result while sequencer idle");

    a_singular_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && singular |-> last && !swap_parity)
        else $error("singular result not marked final");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_SOLVE |=> busy)
        else $error("solve transfer did not start the sequencer");

endmodule

/* bench/tb_top.sv */
// self-checking bench for the lu solver: loads systems, solves, checks every solution element
`timescale 1ns / 1ps

module tb_top;
    import lups_pkg::*;

    typedef logic signed [FX_W-1:0] fx_t;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] sol;
        bit                 last;
        bit                 sing;
        bit                 par;
    } soln_t;

    class lu_scoreboard;
        fx_t   mat [MAX_SIZE*MAX_SIZE];
        fx_t   rhs [MAX_SIZE];
        fx_t   scale [MAX_SIZE];
        int    piv [MAX_SIZE];
        bit    parity;
        int    order;
        soln_t pending [$];
        int    errors;
        int    solves;
        int    singulars;
        int    checked;

        function new();
            for (int i = 0; i < MAX_SIZE*MAX_SIZE; i++) mat[i] = '0;
            for (int i = 0; i < MAX_SIZE; i++)
            begin
                rhs[i] = '0;
                scale[i] = '0;
                piv[i] = 0;
            end
            parity = 0;
            order = 16;
        endfunction

        function int eff_order();
            if (order < 1) return 1;
            if (order > MAX_SIZE) return MAX_SIZE;
            return order;
        endfunction

        function logic [FX_W-1:0] magn(fx_t a);
            return a[FX_W-1] ? (48'd0 - a) : a;
        endfunction

        function fx_t packm(logic [63:0] m, bit neg, bit ovf);
            if (neg)
            begin
                if (ovf || m > 64'h0000_8000_0000_0000) return FX_MIN;
                return fx_t'(48'd0 - m[FX_W-1:0]);
            end
            if (ovf || m > 64'h0000_7FFF_FFFF_FFFF) return FX_MAX;
            return fx_t'(m[FX_W-1:0]);
        endfunction

        function fx_t sub_sat(fx_t a, fx_t b);
            logic signed [FX_W:0] d;
            d = {a[FX_W-1], a} - {b[FX_W-1], b};
            if (d > $signed({1'b0, FX_MAX})) return FX_MAX;
            if (d < $signed({1'b1, FX_MIN})) return FX_MIN;
            return d[FX_W-1:0];
        endfunction

        function logic [63:0] mul_m(logic [FX_W-1:0] ma, logic [FX_W-1:0] mb, inout bit ovf);
            logic [127:0] p;
            p = {80'd0, ma} * {80'd0, mb};
            p = p >> FRAC_BITS;
            if (p > 128'h8000_0000_0000) ovf = 1;
            return p[63:0];
        endfunction

        function logic [63:0] div_m(logic [FX_W-1:0] ma, logic [FX_W-1:0] mb, inout bit ovf);
            logic [127:0] q;
            q = {48'd0, ma, 32'd0} / {80'd0, mb};
            if (q > 128'h8000_0000_0000) ovf = 1;
            return q[63:0];
        endfunction

        function fx_t mul_fx(fx_t a, fx_t b);
            bit          ovf;
            logic [63:0] m;
            ovf = 0;
            m = mul_m(magn(a), magn(b), ovf);
            return packm(m, a[FX_W-1] != b[FX_W-1], ovf);
        endfunction

        function fx_t div_fx(fx_t a, fx_t b);
            bit          ovf;
            logic [63:0] m;
            ovf = 0;
            if (b == 0)
            begin
                if (a == 0) return '0;
                return a[FX_W-1] ? FX_MIN : FX_MAX;
            end
            m = div_m(magn(a), magn(b), ovf);
            return packm(m, a[FX_W-1] != b[FX_W-1], ovf);
        endfunction

        function fx_t from_q(logic signed [31:0] v);
            return fx_t'(v) <<< Q_SHIFT;
        endfunction

        // crout decomposition then both substitutions, pushing the expected elements
        function void run_solve();
            int          n;
            int          imax;
            int          ip;
            fx_t         sum;
            fx_t         big;
            fx_t         dum;
            fx_t         t;
            fx_t         one;
            logic [63:0] m;
            logic [FX_W-1:0] mx;
            bit          ovf;
            soln_t       e;
            n = eff_order();
            one = fx_t'(MAG_ONE);
            parity = 0;
            solves++;
            for (int i = 0; i < n; i++)
            begin
                mx = '0;
                for (int j = 0; j < n; j++)
                    if (magn(mat[i*MAX_SIZE+j]) > mx) mx = magn(mat[i*MAX_SIZE+j]);
                if (mx == 0)
                begin
                    e.idx = IDX_W'(i);
                    e.sol = '0;
                    e.last = 1;
                    e.sing = 1;
                    e.par = 0;
                    pending.push_back(e);
                    singulars++;
                    return;
                end
                ovf = 0;
                m = div_m(MAG_ONE, mx, ovf);
                scale[i] = packm(m, 0, ovf);
            end
            for (int j = 0; j < n; j++)
            begin
                for (int i = 0; i < j; i++)
                begin
                    sum = mat[i*MAX_SIZE+j];
                    for (int k = 0; k < i; k++)
                        sum = sub_sat(sum, mul_fx(mat[i*MAX_SIZE+k], mat[k*MAX_SIZE+j]));
                    mat[i*MAX_SIZE+j] = sum;
                end
                big = '0;
                imax = j;
                for (int i = j; i < n; i++)
                begin
                    sum = mat[i*MAX_SIZE+j];
                    for (int k = 0; k < j; k++)
                        sum = sub_sat(sum, mul_fx(mat[i*MAX_SIZE+k], mat[k*MAX_SIZE+j]));
                    mat[i*MAX_SIZE+j] = sum;
                    ovf = 0;
                    m = mul_m(magn(scale[i]), magn(sum), ovf);
                    dum = packm(m, 0, ovf);
                    if (dum >= big)
                    begin
                        big = dum;
                        imax = i;
                    end
                end
                if (imax != j)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        t = mat[imax*MAX_SIZE+k];
                        mat[imax*MAX_SIZE+k] = mat[j*MAX_SIZE+k];
                        mat[j*MAX_SIZE+k] = t;
                    end
                    parity ^= 1;
                    scale[imax] = scale[j];
                end
                piv[j] = imax;
                // zero pivot stands in as one lsb
                if (mat[j*MAX_SIZE+j] == 0) mat[j*MAX_SIZE+j] = 1;
                if (j != n - 1)
                begin
                    dum = div_fx(one, mat[j*MAX_SIZE+j]);
                    for (int i = j + 1; i < n; i++)
                        mat[i*MAX_SIZE+j] = mul_fx(mat[i*MAX_SIZE+j], dum);
                end
            end
            for (int i = 0; i < n; i++)
            begin
                ip = piv[i] % MAX_SIZE;
                sum = rhs[ip];
                rhs[ip] = rhs[i];
                for (int j = 0; j < i; j++) sum = sub_sat(sum, mul_fx(mat[i*MAX_SIZE+j], rhs[j]));
                rhs[i] = sum;
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                sum = rhs[i];
                for (int j = i + 1; j < n; j++)
                    sum = sub_sat(sum, mul_fx(mat[i*MAX_SIZE+j], rhs[j]));
                rhs[i] = div_fx(sum, mat[i*MAX_SIZE+i]);
            end
            for (int i = 0; i < n; i++)
            begin
                t = rhs[i] >>> Q_SHIFT;
                e.idx = IDX_W'(i);
                e.sol = t[31:0];
                e.last = (i == n - 1);
                e.sing = 0;
                e.par = parity;
                pending.push_back(e);
            end
        endfunction

        function void note_item(logic [1:0] act, int r, int c, logic signed [31:0] v);
            if (act == ACT_MAT) mat[r*MAX_SIZE+c] = from_q(v);
            else if (act == ACT_RHS) rhs[r] = from_q(v);
            else if (act == ACT_SOLVE) run_solve();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        task check(logic [IDX_W-1:0] idx, logic signed [31:0] sol, logic lst, logic sng, logic par);
            soln_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result idx %0d sol %h", idx, sol));
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx || sol !== e.sol || lst !== e.last || sng !== e.sing ||
                par !== e.par)
                report($sformatf("got idx %0d sol %h last %b sing %b par %b, want %0d %h %b %b %b",
                    idx, sol, lst, sng, par, e.idx, e.sol, e.last, e.sing, e.par));
        endtask
    endclass

    localparam int LIMIT = 1_500_000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [31:0] value;
    logic               result_strobe;
    logic [IDX_W-1:0]   row_index;
    logic signed [31:0] solution;
    logic               last;
    logic               singular;
    logic               swap_parity;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data;

    lu_scoreboard sb;
    int  cycles;
    int  idle_pct;
    int  items;
    bit  wmat [MAX_SIZE*MAX_SIZE];
    bit  wrhs [MAX_SIZE];

    lu_pivot_linear_solver_top u_top (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_strobe)
            sb.check(row_index, solution, last, singular, swap_parity);

    function automatic logic signed [31:0] rand_val();
        int sh;
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom();
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:
            begin
                sh = $urandom_range(8, 20);
                return $urandom_range(1) ? -($urandom() >> (32 - sh)) : ($urandom() >> (32 - sh));
            end
        endcase
    endfunction

    task send(logic [1:0] act, int r, int c, logic signed [31:0] v);
        start  <= 1;
        action <= act;
        row    <= IDX_W'(r);
        col    <= IDX_W'(c);
        value  <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(act, r, c, v);
        items++;
        if (act == ACT_MAT) wmat[r*MAX_SIZE+c] = 1;
        if (act == ACT_RHS) wrhs[r] = 1;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // stop sending and let every expected solution element come back
    task drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task set_order(int v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= SIZE_W'(v);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        sb.order = v;
    endtask

    task load_system(int n, bit zero_row);
        int zr;
        zr = zero_row ? $urandom_range(n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                send(ACT_MAT, i, j, (i == zr) ? 32'sd0 : rand_val());
            send(ACT_RHS, i, 0, rand_val());
        end
    endtask

    task solve_now();
        int n;
        n = sb.eff_order();
        // never let the solver read an entry that was never loaded
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                if (!wmat[i*MAX_SIZE+j]) send(ACT_MAT, i, j, rand_val());
            if (!wrhs[i]) send(ACT_RHS, i, 0, rand_val());
        end
        send(ACT_SOLVE, $urandom_range(15), $urandom_range(15), $urandom());
    endtask

    initial
    begin
        int n;
        sb = new();
        cycles = 0;
        items = 0;
        idle_pct = 36;
        rst_n = 0;
        start = 0;
        action = ACT_MAT;
        row = 0;
        col = 0;
        value = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // field extremes, ignored action, loads at the top index
        send(ACT_MAT, 15, 15, 32'sh7FFF_FFFF);
        send(ACT_MAT, 15, 0, 32'sh8000_0000);
        send(ACT_RHS, 15, 15, 32'sh8000_0000);
        send(ACT_UNUSED, 15, 15, $urandom());
        send(ACT_RHS, 0, 0, 0);

        // interchange needed, then a repeated solve on the stored factors
        set_order(2);
        send(ACT_MAT, 0, 0, 0);
        send(ACT_MAT, 0, 1, 32'sh0001_0000);
        send(ACT_MAT, 1, 0, 32'sh0001_0000);
        send(ACT_MAT, 1, 1, 0);
        send(ACT_RHS, 0, 0, 32'sh0003_0000);
        send(ACT_RHS, 1, 0, 32'sh0005_0000);
        solve_now();
        solve_now();
        // all-zero row
        send(ACT_MAT, 1, 0, 0);
        send(ACT_MAT, 1, 1, 0);
        solve_now();
        // dependent rows give a zero pivot
        send(ACT_MAT, 0, 0, 32'sh0001_0000);
        send(ACT_MAT, 0, 1, 32'sh0001_0000);
        send(ACT_MAT, 1, 0, 32'sh0001_0000);
        send(ACT_MAT, 1, 1, 32'sh0001_0000);
        solve_now();
        // tiny against huge drives saturation
        send(ACT_MAT, 0, 0, 1);
        send(ACT_MAT, 0, 1, 32'sh7FFF_FFFF);
        send(ACT_MAT, 1, 0, 32'sh8000_0000);
        send(ACT_MAT, 1, 1, 1);
        send(ACT_RHS, 0, 0, 32'sh7FFF_FFFF);
        solve_now();

        // size zero acts as one
        set_order(0);
        send(ACT_MAT, 0, 0, 32'sh0000_8000);
        solve_now();

        // random systems, mostly small, idling in three phases
        for (int rnd = 0; items < 150; rnd++)
        begin
            idle_pct = (items < 80) ? 36 : (items < 120) ? 69 : 0;
            if (rnd % 3 == 0) set_order($urandom_range(1, 5));
            n = sb.eff_order();
            load_system(n, $urandom_range(7) == 0);
            if ($urandom_range(3) == 0)
                send($urandom_range(1) ? ACT_UNUSED : ACT_RHS, $urandom_range(15),
                     $urandom_range(15), rand_val());
            solve_now();
            if ($urandom_range(3) == 0) solve_now();
            if (rnd == 8) drain();
        end

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d items, %0d solves (%0d singular), %0d solution elements checked",
            items, sb.solves, sb.singulars, sb.checked);
        $display("orders 0 through 5; interchange, zero pivot and saturation cases");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
